// ===== rtl/longest_window_with_k_replacements_unit_defines.svh =====
// assertion macros for the longest-window unit
// used by the top level only, no other dependencies
`ifndef LONGEST_WINDOW_WITH_K_REPLACEMENTS_UNIT_DEFINES_SVH
`define LONGEST_WINDOW_WITH_K_REPLACEMENTS_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LWKR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LWKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lwkr_pkg.sv =====
// shared constants and types for the longest-window unit
// no dependencies
`timescale 1ns / 1ps

package lwkr_pkg;

	// fixed field widths
	localparam int LTR_W          = 5;
	localparam int LEN_W          = 13;
	localparam int CFG_W          = 13;
	localparam int IN_TDATA_W     = 8;
	localparam int OUT_TDATA_W    = 16;

	// alphabet size and default history depth
	localparam int ALPHABET       = 26;
	localparam int MAX_STRING_DEF = 4096;

	// one input word handed to the core, with its accept flag
	typedef struct packed {
		logic             take;
		logic [LTR_W-1:0] letter;
		logic             first;
	} step_t;

	// result of the word in flight
	typedef struct packed {
		logic [LEN_W-1:0] longest;
		logic             ovf;
	} result_t;

endpackage

// ===== rtl/longest_window_with_k_replacements_unit.sv =====
// Longest window of one repeated letter with at most max_replacements letters
// replaced. One word in, one result word out; a word is taken every cycle
// unless a full output register is stalled, and its result is registered on
// acceptance. The rate is set by the occurrence-counter update and the history
// ram, whose registered read of the window's left edge is issued ahead with a
// bypass for a same-cycle write. The history holds MAX_STRING letters per
// string and needs no clearing pass after reset; a longer string raises the
// sticky overflow flag and freezes the length until the next string start.
// max_replacements may only be written while no word is in flight.
// depends on lwkr_pkg, lwkr_core and the assertion macro header
`timescale 1ns / 1ps
`include "longest_window_with_k_replacements_unit_defines.svh"

module longest_window_with_k_replacements_unit #(
	parameter int MAX_STRING = lwkr_pkg::MAX_STRING_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lwkr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [4:0] letter
	input  logic                             s_tuser,   // [0] first_of_string
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lwkr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [12:0] longest_length
	output logic                             m_tuser,   // [0] overflow
	input  logic                             cfg_we,
	input  logic [lwkr_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int LW  = lwkr_pkg::LTR_W;
	localparam int PAD = lwkr_pkg::OUT_TDATA_W - lwkr_pkg::LEN_W;

	logic [lwkr_pkg::CFG_W-1:0] max_repl_q;
	logic                       acc;
	lwkr_pkg::step_t            step;
	lwkr_pkg::result_t          res;
	logic                       out_valid_q;
	lwkr_pkg::result_t          out_q;

	// replacement limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repl_q <= '0;
		end else if (cfg_we) begin
			max_repl_q <= cfg_wdata;
		end
	end

	// input handshake
	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		step.take   = acc;
		step.letter = s_tdata[LW-1:0];
		step.first  = s_tuser;
	end

	lwkr_core #(
		.MAX_STRING(MAX_STRING)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.max_repl(max_repl_q),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (acc) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD{1'b0}}, out_q.longest};
	assign m_tuser  = out_q.ovf;

	// a new string always starts without overflow
	`LWKR_ASSERT_NEXT(a_first_clears_ovf, clk, arst_n, acc && s_tuser, m_tvalid && !m_tuser, "overflow set on first word of a string")

	// overflow stays set until the next string start
	`LWKR_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, acc && !s_tuser && m_tuser, m_tuser, "overflow dropped inside a string")

	// an empty output register never stalls the input
	`LWKR_ASSERT_NOW(a_empty_ready, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output register")

endmodule

// ===== rtl/lwkr_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on lwkr_pkg for default sizes
`timescale 1ns / 1ps

module lwkr_ram #(
	parameter int WIDTH = lwkr_pkg::LTR_W,
	parameter int DEPTH = lwkr_pkg::MAX_STRING_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lwkr_core.sv =====
// window datapath: occurrence counters, window registers, history ram
// depends on lwkr_pkg and lwkr_ram
`timescale 1ns / 1ps

module lwkr_core #(
	parameter int MAX_STRING = lwkr_pkg::MAX_STRING_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lwkr_pkg::step_t           step,
	input  logic [lwkr_pkg::CFG_W-1:0] max_repl,
	output lwkr_pkg::result_t         res
);

	localparam int LW    = lwkr_pkg::LTR_W;
	localparam int LENW  = lwkr_pkg::LEN_W;
	localparam int NLTR  = lwkr_pkg::ALPHABET;
	localparam int CNT_W = $clog2(MAX_STRING + 1);
	localparam int AW    = $clog2(MAX_STRING);
	localparam int CMP_W = (CNT_W > lwkr_pkg::CFG_W) ? CNT_W : lwkr_pkg::CFG_W;
	localparam int HW    = CNT_W + LW;

	// per-letter occurrence totals and per-letter dropped totals
	logic [CNT_W-1:0] pc_q [NLTR];
	logic [CNT_W-1:0] rm_q [NLTR];

	logic [AW-1:0]    left_q;
	logic [CNT_W-1:0] wpos_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] top_q;
	logic [CNT_W-1:0] best_q;
	logic             ovf_q;

	// head of window: bypass of a same-cycle write to the read address
	logic             byp_s1;
	logic [HW-1:0]    byp_data_s1;
	logic [HW-1:0]    ram_rdata;
	logic [HW-1:0]    head;
	logic [LW-1:0]    drop_let;
	logic [CNT_W-1:0] drop_occ;

	logic [AW-1:0]    eff_left;
	logic [CNT_W-1:0] eff_wpos;
	logic [CNT_W-1:0] eff_len;
	logic [CNT_W-1:0] eff_top;
	logic [CNT_W-1:0] eff_best;
	logic             eff_ovf;

	logic             letter_ok;
	logic             full;
	logic             do_take;
	logic             set_ovf;
	logic [LW-1:0]    lidx;
	logic [CNT_W-1:0] pc_rd;
	logic [CNT_W-1:0] rm_rd;
	logic [CNT_W-1:0] occ;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] top_n;
	logic [CNT_W-1:0] len_n;
	logic [CNT_W-1:0] diff;
	logic             need_drop;
	logic [CNT_W-1:0] len_f;
	logic [CNT_W-1:0] best_n;
	logic [AW-1:0]    left_nx;
	logic [AW-1:0]    waddr;
	logic [HW-1:0]    wdata;

	assign head     = byp_s1 ? byp_data_s1 : ram_rdata;
	assign drop_let = head[LW-1:0];
	assign drop_occ = head[HW-1:LW];

	// state as seen by this word, after an optional string clear
	always_comb begin
		eff_left = step.first ? '0 : left_q;
		eff_wpos = step.first ? '0 : wpos_q;
		eff_len  = step.first ? '0 : len_q;
		eff_top  = step.first ? '0 : top_q;
		eff_best = step.first ? '0 : best_q;
		eff_ovf  = step.first ? 1'b0 : ovf_q;
	end

	// decide take, overflow and left-edge drop
	always_comb begin
		letter_ok = step.letter < LW'(NLTR);
		full      = eff_wpos >= CNT_W'(MAX_STRING);
		do_take   = step.take && letter_ok && !eff_ovf && !full;
		set_ovf   = step.take && letter_ok && !eff_ovf && full;
		lidx      = letter_ok ? step.letter : '0;
		pc_rd     = step.first ? '0 : pc_q[lidx];
		rm_rd     = step.first ? '0 : rm_q[lidx];
		occ       = pc_rd + CNT_W'(1);
		cnt       = occ - rm_rd;
		top_n     = (cnt > eff_top) ? cnt : eff_top;
		len_n     = eff_len + CNT_W'(1);
		diff      = len_n - top_n;
		need_drop = (len_n > top_n) && (CMP_W'(diff) > CMP_W'(max_repl));
		len_f     = need_drop ? eff_len : len_n;
		best_n    = (len_f > eff_best) ? len_f : eff_best;
		if (!step.take) begin
			left_nx = left_q;
		end else if (do_take && need_drop) begin
			left_nx = eff_left + AW'(1);
		end else begin
			left_nx = eff_left;
		end
		waddr = eff_wpos[AW-1:0];
		wdata = {occ, step.letter};
	end

	// result of this word
	always_comb begin
		res.longest = do_take ? LENW'(best_n) : LENW'(eff_best);
		res.ovf     = eff_ovf | set_ovf;
	end

	// history of letters tagged with their occurrence number
	lwkr_ram #(
		.WIDTH(HW),
		.DEPTH(MAX_STRING)
	) u_hist (
		.clk  (clk),
		.we   (do_take),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(left_nx),
		.rdata(ram_rdata)
	);

	// head bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s1 <= 1'b0;
		end else begin
			byp_s1 <= do_take && (waddr == left_nx);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_s1 <= wdata;
	end

	// occurrence counters: clear on new string, bump taken letter, mark drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NLTR; i++) begin
				pc_q[i] <= '0;
				rm_q[i] <= '0;
			end
		end else if (step.take) begin
			for (int i = 0; i < NLTR; i++) begin
				if (do_take && (LW'(i) == lidx)) begin
					pc_q[i] <= occ;
				end else if (step.first) begin
					pc_q[i] <= '0;
				end
				if (do_take && need_drop && (LW'(i) == drop_let)) begin
					rm_q[i] <= drop_occ;
				end else if (step.first) begin
					rm_q[i] <= '0;
				end
			end
		end
	end

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			wpos_q <= '0;
			len_q  <= '0;
			top_q  <= '0;
			best_q <= '0;
			ovf_q  <= 1'b0;
		end else if (step.take) begin
			left_q <= left_nx;
			wpos_q <= do_take ? eff_wpos + CNT_W'(1) : eff_wpos;
			len_q  <= do_take ? len_f : eff_len;
			top_q  <= do_take ? top_n : eff_top;
			best_q <= do_take ? best_n : eff_best;
			ovf_q  <= eff_ovf | set_ovf;
		end
	end

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the longest-window unit: streams letters, predicts each result word
// depends on lwkr_pkg and longest_window_with_k_replacements_unit
`timescale 1ns / 1ps

module tb;

	localparam int HIST_DEPTH = lwkr_pkg::MAX_STRING_DEF;
	localparam int LONG_HOLD  = 80;

	// one letter word as offered on the input stream
	typedef struct packed {
		logic [lwkr_pkg::LTR_W-1:0] letter;
		logic                       fresh;
	} letter_word_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [lwkr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;    // [4:0] letter
	logic                             s_tuser = 1'b0;  // [0] first_of_string
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [lwkr_pkg::OUT_TDATA_W-1:0] m_tdata;         // [12:0] longest_length
	logic                             m_tuser;         // [0] overflow
	logic                             cfg_we = 1'b0;
	logic [lwkr_pkg::CFG_W-1:0]       cfg_wdata = '0;

	longest_window_with_k_replacements_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// letters waiting to be sent and answers waiting to come back
	letter_word_t      letter_q[$];
	lwkr_pkg::result_t answer_q[$];
	letter_word_t      offered;

	// shadow of the window tracker
	int         hits[lwkr_pkg::ALPHABET];
	logic [4:0] history[HIST_DEPTH];
	int         left_pos, wr_pos, win_len, top_hits, best_len;
	bit         ovf_seen;
	int         k_limit = 0;

	// pacing controls; the burst and hold flags are set by the stimulus process
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_arm = 1'b0;
	int tx_gap = 0;
	int rx_stall = 0;

	int fails = 0;
	int words_sent = 0;
	int words_checked = 0;
	int strings_started = 0;
	int ovf_words = 0;
	int peak_len = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$error("run did not finish in time, %0d answers outstanding", answer_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void clear_window();
		for (int i = 0; i < lwkr_pkg::ALPHABET; i++)
			hits[i] = 0;
		left_pos = 0;
		wr_pos   = 0;
		win_len  = 0;
		top_hits = 0;
		best_len = 0;
		ovf_seen = 1'b0;
	endfunction

	// advance the shadow window by one accepted letter and queue the answer
	function automatic void take_letter(letter_word_t w);
		lwkr_pkg::result_t ans;
		int                drop;
		if (w.fresh) begin
			clear_window();
			strings_started++;
		end
		if (int'(w.letter) < lwkr_pkg::ALPHABET && !ovf_seen) begin
			if (wr_pos >= HIST_DEPTH) begin
				ovf_seen = 1'b1;
			end else begin
				history[wr_pos] = w.letter;
				wr_pos++;
				hits[w.letter]++;
				if (hits[w.letter] > top_hits)
					top_hits = hits[w.letter];
				win_len++;
				// slide the left edge by one when too many letters need replacing
				if (win_len > top_hits && win_len - top_hits > k_limit && left_pos < wr_pos) begin
					drop = history[left_pos];
					if (hits[drop] > 0)
						hits[drop]--;
					left_pos++;
					win_len--;
				end
				if (win_len > best_len)
					best_len = win_len;
			end
		end
		ans.longest = best_len[lwkr_pkg::LEN_W-1:0];
		ans.ovf     = ovf_seen;
		if (best_len > peak_len)
			peak_len = best_len;
		answer_q.insert(answer_q.size(), ans);
	endfunction

	// input side: one word per handshake, random gap before each new word outside bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				take_letter(offered);
				words_sent++;
				tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (letter_q.size() > 0) begin
					offered = letter_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(lwkr_pkg::IN_TDATA_W - lwkr_pkg::LTR_W){1'b0}},
						offered.letter};
					s_tuser  <= offered.fresh;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: compare each result word with the oldest answer
	always @(posedge clk) begin
		lwkr_pkg::result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					$error("result word with nothing expected: length %0d overflow %0b",
						m_tdata[lwkr_pkg::LEN_W-1:0], m_tuser);
					fails++;
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[lwkr_pkg::LEN_W-1:0] !== want.longest) begin
						$error("longest_length: expected %0d, got %0d",
							want.longest, m_tdata[lwkr_pkg::LEN_W-1:0]);
						fails++;
					end
					if (m_tuser !== want.ovf) begin
						$error("overflow: expected %0b, got %0b", want.ovf, m_tuser);
						fails++;
					end
					words_checked++;
					if (want.ovf)
						ovf_words++;
				end
				rx_stall = rx_burst ? 0 : $urandom_range(0, 3);
			end
			// long back-pressure so the unit fills up and stalls its input
			if (hold_arm) begin
				hold_arm = 1'b0;
				rx_stall = LONG_HOLD;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_word(input int letter, input bit fresh);
		letter_word_t w;
		w.letter = letter[lwkr_pkg::LTR_W-1:0];
		w.fresh  = fresh;
		letter_q.insert(letter_q.size(), w);
	endtask

	// one string drawn from a span of neighboring letters, with a little noise
	task automatic add_string(input int len, input bit fresh, input int span);
		int base;
		base = $urandom_range(0, lwkr_pkg::ALPHABET - span);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 4)
				push_word($urandom_range(lwkr_pkg::ALPHABET, 31), fresh && i == 0);
			else
				push_word(base + $urandom_range(0, span - 1), fresh && i == 0);
		end
	endtask

	// wait until every word is sent and every answer has come back
	task automatic drain();
		@(negedge clk);
		while (letter_q.size() > 0 || s_tvalid || answer_q.size() > 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_limit(input int v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v[lwkr_pkg::CFG_W-1:0];
		k_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus sequence
	initial begin
		int limits[6];
		int total;
		int len;
		int span;
		clear_window();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words under the reset limit of zero, including ignored letters
		push_word(0, 1);  push_word(0, 0);  push_word(1, 0);  push_word(0, 0);
		push_word(25, 0); push_word(26, 0); push_word(31, 0);
		push_word(31, 1); push_word(16, 0); push_word(16, 0); push_word(15, 0);
		push_word(16, 0);
		drain();

		// limit raised mid-string, then lowered mid-string
		write_limit(2);
		push_word(15, 0); push_word(15, 0); push_word(16, 0);
		push_word(8, 0);  push_word(16, 0); push_word(16, 0);
		drain();
		write_limit(0);
		push_word(1, 0);  push_word(2, 0);  push_word(3, 0);
		push_word(16, 0); push_word(16, 0); push_word(16, 0);
		drain();

		// random phases, each under its own limit; odd phases keep the open string
		limits = '{1, 4096, 0, $urandom_range(0, 6), 2, $urandom_range(0, 4096)};
		for (int p = 0; p < 6; p++) begin
			write_limit(limits[p]);
			tx_burst = (p == 2);
			rx_burst = (p == 4);
			total = 0;
			while (total < 140) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(100, 300);
				else
					len = $urandom_range(1, 40);
				span = ($urandom_range(0, 5) == 0) ? lwkr_pkg::ALPHABET : $urandom_range(1, 4);
				add_string(len, !(total == 0 && p[0]), span);
				total += len;
			end
			if (p == 1) begin
				@(negedge clk);
				hold_arm = 1'b1;
			end
			drain();
		end

		repeat (5) @(posedge clk);
		$display("run covered %0d words in %0d strings, %0d results checked",
			words_sent, strings_started, words_checked);
		$display("%0d results carried overflow, longest window seen %0d", ovf_words, peak_len);
		if (fails == 0 && answer_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lwkr_pkg.sv
rtl/lwkr_ram.sv
rtl/lwkr_core.sv
rtl/longest_window_with_k_replacements_unit.sv
bench/tb.sv
